### sv/http_date_parser_defines.svh
// assertion macros for the http date parser
// no dependencies; included by the files that carry assertions
`ifndef HTTP_DATE_PARSER_DEFINES_SVH
`define HTTP_DATE_PARSER_DEFINES_SVH
`ifndef ASSERT_OFF
`define HDP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("hdp assertion failed");
`define HDP_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("hdp reset assertion failed");
`else
`define HDP_ASSERT(lbl, clk, rst_n, prop)
`define HDP_ASSERT_RST(lbl, clk, prop)
`endif
`endif

### sv/hdp_pkg.sv
// shared widths, field struct and month tables for the http date parser
// no dependencies
package hdp_pkg;

  localparam int MAX_NUM_DIGITS = 4;
  localparam int ACC_W   = $clog2(10 ** MAX_NUM_DIGITS);
  localparam int YEAR_W  = $clog2(10 ** MAX_NUM_DIGITS + 400);
  localparam int DAY_W   = YEAR_W + 14;
  localparam int SEC_W   = 39;
  localparam int TV_W    = 7;
  localparam int HMS_W   = 19;
  localparam int REST_W  = 21;
  localparam int DOY_W   = 9;
  localparam int DC_W    = 3;

  // floor(y / 100) by reciprocal multiply, exact for y below 2**YEAR_W
  localparam int RECIP_SH = YEAR_W + 7;
  localparam int RECIP_W  = YEAR_W + 1;
  localparam int PROD_W   = YEAR_W + RECIP_W;
  localparam int Q_W      = PROD_W - RECIP_SH;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SH) + 64'd99) / 64'd100);

  // days from 0000-03-01 shifted by 400 years to 1970-01-01
  localparam logic signed [DAY_W-1:0] EPOCH_OFS = DAY_W'(865565);
  localparam logic signed [SEC_W-1:0] SEC_PER_DAY = SEC_W'(86400);

  typedef struct packed {
    logic              fmt_ok;
    logic              zone_num;
    logic [ACC_W-1:0]  year;
    logic [ACC_W-1:0]  day;
    logic [14:0]       mon;
    logic [TV_W-1:0]   hour;
    logic [TV_W-1:0]   minute;
    logic [TV_W-1:0]   second;
    logic              zneg;
    logic [TV_W-1:0]   zhour;
    logic [TV_W-1:0]   zmin;
  } hdp_fields_t;

  function automatic logic [14:0] mcode(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    mcode = {5'(a - 8'h61), 5'(b - 8'h61), 5'(c - 8'h61)};
  endfunction

  localparam logic [14:0] MONTH_CODES [12] = '{
    mcode("j", "a", "n"), mcode("f", "e", "b"), mcode("m", "a", "r"),
    mcode("a", "p", "r"), mcode("m", "a", "y"), mcode("j", "u", "n"),
    mcode("j", "u", "l"), mcode("a", "u", "g"), mcode("s", "e", "p"),
    mcode("o", "c", "t"), mcode("n", "o", "v"), mcode("d", "e", "c")
  };

  // {found, index} for a packed month name
  function automatic logic [4:0] month_lookup(logic [14:0] ml);
    logic [4:0] res;
    res = 5'd0;
    for (int i = 11; i >= 0; i--) begin
      if (ml == MONTH_CODES[i]) begin
        res = {1'b1, 4'(i)};
      end
    end
    return res;
  endfunction

  // day of a march-based year at which a month starts
  function automatic logic [DOY_W-1:0] month_doy(logic [3:0] idx);
    logic [DOY_W-1:0] d;
    case (idx)
      4'd0:    d = 9'd306;
      4'd1:    d = 9'd337;
      4'd2:    d = 9'd0;
      4'd3:    d = 9'd31;
      4'd4:    d = 9'd61;
      4'd5:    d = 9'd92;
      4'd6:    d = 9'd122;
      4'd7:    d = 9'd153;
      4'd8:    d = 9'd184;
      4'd9:    d = 9'd214;
      4'd10:   d = 9'd245;
      4'd11:   d = 9'd275;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

### sv/hdp_parser.sv
// character-level pattern checker and field capture
// depends on hdp_pkg and http_date_parser_defines.svh
`include "http_date_parser_defines.svh"
module hdp_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_acc,
  input  logic [7:0]          in_char,
  input  logic                in_last,
  output logic                fld_valid,
  output hdp_pkg::hdp_fields_t fld
);
  import hdp_pkg::*;

  typedef enum logic [25:0] {
    PH_WD     = 26'd1 << 0,  PH_COMMA  = 26'd1 << 1,  PH_SP1    = 26'd1 << 2,
    PH_SP1B   = 26'd1 << 3,  PH_DAY    = 26'd1 << 4,  PH_SP2    = 26'd1 << 5,
    PH_MON    = 26'd1 << 6,  PH_MONEND = 26'd1 << 7,  PH_SP3    = 26'd1 << 8,
    PH_YEAR   = 26'd1 << 9,  PH_SP4    = 26'd1 << 10, PH_HH2    = 26'd1 << 11,
    PH_C1     = 26'd1 << 12, PH_MM1    = 26'd1 << 13, PH_MM2    = 26'd1 << 14,
    PH_C2     = 26'd1 << 15, PH_SS1    = 26'd1 << 16, PH_SS2    = 26'd1 << 17,
    PH_SPZ    = 26'd1 << 18, PH_ZSTART = 26'd1 << 19, PH_ZNAME  = 26'd1 << 20,
    PH_ZD1    = 26'd1 << 21, PH_ZD2    = 26'd1 << 22, PH_ZD3    = 26'd1 << 23,
    PH_ZD4    = 26'd1 << 24, PH_END    = 26'd1 << 25
  } hdp_phase_t;

  hdp_phase_t       phase_r, phase_nxt;
  logic [DC_W-1:0]  dc_r, dc_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [ACC_W-1:0] day_r, day_nxt;
  logic [ACC_W-1:0] year_r, year_nxt;
  logic [14:0]      mon_r, mon_nxt;
  logic [TV_W-1:0]  hour_r, hour_nxt, min_r, min_nxt, sec_r, sec_nxt;
  logic [TV_W-1:0]  zh_r, zh_nxt;
  logic             zneg_r, zneg_nxt, zok_r, zok_nxt, err_r, err_nxt;

  logic             dig, is_let, sp, ok;
  logic [3:0]       dv;
  logic [7:0]       lc, gchar;
  logic [4:0]       lidx;

  // character classes
  always_comb begin
    dig    = (in_char >= "0") && (in_char <= "9");
    dv     = dig ? 4'(in_char - 8'h30) : 4'd0;
    lc     = in_char | 8'h20;
    is_let = !in_char[7] && (lc >= "a") && (lc <= "z");
    sp     = (in_char == " ");
    lidx   = 5'(lc - 8'h61);
    case (dc_r)
      3'd0:    gchar = "g";
      3'd1:    gchar = "m";
      3'd2:    gchar = "t";
      default: gchar = 8'h00;
    endcase
  end

  // next phase and captured fields
  always_comb begin
    phase_nxt = phase_r;
    dc_nxt    = dc_r;
    acc_nxt   = acc_r;
    day_nxt   = day_r;
    year_nxt  = year_r;
    mon_nxt   = mon_r;
    hour_nxt  = hour_r;
    min_nxt   = min_r;
    sec_nxt   = sec_r;
    zh_nxt    = zh_r;
    zneg_nxt  = zneg_r;
    zok_nxt   = zok_r;
    err_nxt   = err_r;
    ok        = 1'b0;
    if (!err_r) begin
      case (phase_r)
        PH_WD: if (is_let) begin
          ok = 1'b1;
          if (dc_r >= 3'd2) begin
            dc_nxt    = 3'd0;
            phase_nxt = PH_COMMA;
          end else begin
            dc_nxt = dc_r + 3'd1;
          end
        end
        PH_COMMA: if (in_char == ",") begin
          ok        = 1'b1;
          phase_nxt = PH_SP1;
        end
        PH_SP1: if (sp) begin
          ok        = 1'b1;
          phase_nxt = PH_SP1B;
        end
        PH_SP1B, PH_SP3: begin
          if (sp) begin
            ok = 1'b1;
          end else if (dig) begin
            ok        = 1'b1;
            acc_nxt   = ACC_W'(dv);
            dc_nxt    = 3'd1;
            phase_nxt = (phase_r == PH_SP1B) ? PH_DAY : PH_YEAR;
          end
        end
        PH_DAY, PH_YEAR: begin
          if (dig) begin
            ok = 1'b1;
            if (dc_r >= DC_W'(MAX_NUM_DIGITS)) begin
              err_nxt = 1'b1;
            end else begin
              acc_nxt = ACC_W'(acc_r * ACC_W'(10) + ACC_W'(dv));
              dc_nxt  = dc_r + 3'd1;
            end
          end else if (sp) begin
            ok = 1'b1;
            if (phase_r == PH_DAY) begin
              day_nxt   = acc_r;
              phase_nxt = PH_SP2;
            end else begin
              year_nxt  = acc_r;
              phase_nxt = PH_SP4;
            end
          end
        end
        PH_SP2: begin
          if (sp) begin
            ok = 1'b1;
          end else if (is_let) begin
            ok        = 1'b1;
            mon_nxt   = 15'(lidx);
            dc_nxt    = 3'd1;
            phase_nxt = PH_MON;
          end
        end
        PH_MON: if (is_let) begin
          ok      = 1'b1;
          mon_nxt = {mon_r[9:0], lidx};
          if (dc_r >= 3'd2) begin
            dc_nxt    = 3'd0;
            phase_nxt = PH_MONEND;
          end else begin
            dc_nxt = dc_r + 3'd1;
          end
        end
        PH_MONEND: if (sp) begin
          ok        = 1'b1;
          phase_nxt = PH_SP3;
        end
        PH_SP4: begin
          if (sp) begin
            ok = 1'b1;
          end else if (dig) begin
            ok        = 1'b1;
            hour_nxt  = TV_W'(dv);
            phase_nxt = PH_HH2;
          end
        end
        PH_HH2: if (dig) begin
          ok        = 1'b1;
          hour_nxt  = TV_W'(hour_r * TV_W'(10) + TV_W'(dv));
          phase_nxt = PH_C1;
        end
        PH_C1: if (in_char == ":") begin
          ok        = 1'b1;
          phase_nxt = PH_MM1;
        end
        PH_MM1: if (dig) begin
          ok        = 1'b1;
          min_nxt   = TV_W'(dv);
          phase_nxt = PH_MM2;
        end
        PH_MM2: if (dig) begin
          ok        = 1'b1;
          min_nxt   = TV_W'(min_r * TV_W'(10) + TV_W'(dv));
          phase_nxt = PH_C2;
        end
        PH_C2: if (in_char == ":") begin
          ok        = 1'b1;
          phase_nxt = PH_SS1;
        end
        PH_SS1: if (dig) begin
          ok        = 1'b1;
          sec_nxt   = TV_W'(dv);
          phase_nxt = PH_SS2;
        end
        PH_SS2: if (dig) begin
          ok        = 1'b1;
          sec_nxt   = TV_W'(sec_r * TV_W'(10) + TV_W'(dv));
          phase_nxt = PH_SPZ;
        end
        PH_SPZ: if (sp) begin
          ok        = 1'b1;
          phase_nxt = PH_ZSTART;
        end
        PH_ZSTART: begin
          if (sp) begin
            ok = 1'b1;
          end else if (is_let) begin
            ok        = 1'b1;
            zok_nxt   = zok_r & (lc == "g");
            dc_nxt    = 3'd1;
            phase_nxt = PH_ZNAME;
          end else if ((in_char == "+") || (in_char == "-")) begin
            ok        = 1'b1;
            zneg_nxt  = (in_char == "-");
            phase_nxt = PH_ZD1;
          end
        end
        PH_ZNAME: if (is_let) begin
          ok = 1'b1;
          if ((dc_r >= 3'd3) || (lc != gchar)) begin
            zok_nxt = 1'b0;
          end
          if (dc_r < 3'd7) begin
            dc_nxt = dc_r + 3'd1;
          end
        end
        PH_ZD1: if (dig) begin
          ok        = 1'b1;
          zh_nxt    = TV_W'(dv);
          phase_nxt = PH_ZD2;
        end
        PH_ZD2: if (dig) begin
          ok        = 1'b1;
          zh_nxt    = TV_W'(zh_r * TV_W'(10) + TV_W'(dv));
          phase_nxt = PH_ZD3;
        end
        PH_ZD3: if (dig) begin
          ok        = 1'b1;
          acc_nxt   = ACC_W'(dv);
          phase_nxt = PH_ZD4;
        end
        PH_ZD4: if (dig) begin
          ok        = 1'b1;
          acc_nxt   = ACC_W'(acc_r * ACC_W'(10) + ACC_W'(dv));
          phase_nxt = PH_END;
        end
        default: ok = 1'b0;
      endcase
      if (!ok) begin
        err_nxt = 1'b1;
      end
    end
  end

  // fields handed to the seconds pipeline on the last character
  always_comb begin
    fld_valid    = in_acc && in_last;
    fld.fmt_ok   = !err_nxt && (((phase_nxt == PH_ZNAME) && zok_nxt && (dc_nxt == 3'd3)) ||
                                (phase_nxt == PH_END));
    fld.zone_num = (phase_nxt == PH_END);
    fld.year     = year_nxt;
    fld.day      = day_nxt;
    fld.mon      = mon_nxt;
    fld.hour     = hour_nxt;
    fld.minute   = min_nxt;
    fld.second   = sec_nxt;
    fld.zneg     = zneg_nxt;
    fld.zhour    = zh_nxt;
    fld.zmin     = TV_W'(acc_nxt);
  end

  // parser state, back to the start after every last character
  always_ff @(posedge clk) begin
    if (!rst_n || (in_acc && in_last)) begin
      phase_r <= PH_WD;
      dc_r    <= '0;
      acc_r   <= '0;
      day_r   <= '0;
      year_r  <= '0;
      mon_r   <= '0;
      hour_r  <= '0;
      min_r   <= '0;
      sec_r   <= '0;
      zh_r    <= '0;
      zneg_r  <= 1'b0;
      zok_r   <= 1'b1;
      err_r   <= 1'b0;
    end else if (in_acc) begin
      phase_r <= phase_nxt;
      dc_r    <= dc_nxt;
      acc_r   <= acc_nxt;
      day_r   <= day_nxt;
      year_r  <= year_nxt;
      mon_r   <= mon_nxt;
      hour_r  <= hour_nxt;
      min_r   <= min_nxt;
      sec_r   <= sec_nxt;
      zh_r    <= zh_nxt;
      zneg_r  <= zneg_nxt;
      zok_r   <= zok_nxt;
      err_r   <= err_nxt;
    end
  end

  `HDP_ASSERT(a_last_clears, clk, rst_n, in_acc && in_last |=> phase_r == PH_WD && !err_r && dc_r == 3'd0)
  `HDP_ASSERT(a_err_sticky, clk, rst_n, err_r && !(in_acc && in_last) |=> err_r)
  `HDP_ASSERT(a_count_bound, clk, rst_n, phase_r != PH_ZNAME |-> dc_r <= DC_W'(MAX_NUM_DIGITS))

endmodule

### sv/hdp_epoch.sv
// pipeline from captured date fields to utc seconds, ending in the output register
// depends on hdp_pkg
module hdp_epoch (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 fld_valid,
  input  hdp_pkg::hdp_fields_t fld,
  output logic                 res_valid,
  output logic                 res_ok,
  output logic [hdp_pkg::SEC_W-1:0] res_secs
);
  import hdp_pkg::*;

  logic                     v1_r, v2_r, v3_r, v4_r, vo_r;
  hdp_fields_t              f1_r;
  logic                     ok2_r, ok3_r, ok4_r, oko_r;
  logic [YEAR_W-1:0]        y2_r, y3_r;
  logic signed [DAY_W-1:0]  base2_r, base3_r;
  logic signed [REST_W-1:0] rest2_r, rest3_r, rest4_r;
  logic [PROD_W-1:0]        prod3_r;
  logic signed [DAY_W-1:0]  days4_r;
  logic [SEC_W-1:0]         secs_r;

  logic [4:0]               mlook;
  logic [HMS_W-1:0]         hms, tz;
  logic [YEAR_W-1:0]        y_s2;
  logic signed [DAY_W-1:0]  base_s2, days_s4;
  logic signed [REST_W-1:0] rest_s2;
  logic [Q_W-1:0]           q100;
  logic signed [SEC_W-1:0]  secs_s5;

  // month, march-based year, hms and zone terms
  always_comb begin
    mlook   = month_lookup(f1_r.mon);
    y_s2    = YEAR_W'(f1_r.year) + YEAR_W'(400) - YEAR_W'(mlook[3:0] < 4'd2);
    base_s2 = DAY_W'(month_doy(mlook[3:0])) + DAY_W'(f1_r.day) - DAY_W'(1);
    hms     = HMS_W'(HMS_W'(f1_r.hour) * HMS_W'(3600)) +
              HMS_W'(HMS_W'(f1_r.minute) * HMS_W'(60)) + HMS_W'(f1_r.second);
    tz      = HMS_W'(HMS_W'(f1_r.zhour) * HMS_W'(3600)) +
              HMS_W'(HMS_W'(f1_r.zmin) * HMS_W'(60));
    if (!f1_r.zone_num) begin
      rest_s2 = REST_W'(hms);
    end else if (f1_r.zneg) begin
      rest_s2 = REST_W'(hms) + REST_W'(tz);
    end else begin
      rest_s2 = REST_W'(hms) - REST_W'(tz);
    end
  end

  // day count from the year quotient, and seconds from the day count
  always_comb begin
    q100    = prod3_r[PROD_W-1:RECIP_SH];
    days_s4 = DAY_W'(y3_r) * DAY_W'(365) + DAY_W'(y3_r >> 2) - DAY_W'(q100) +
              DAY_W'(q100 >> 2) + base3_r - EPOCH_OFS;
    secs_s5 = SEC_W'(days4_r) * SEC_PER_DAY + SEC_W'(rest4_r);
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      vo_r <= 1'b0;
    end else if (en) begin
      v1_r <= fld_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      vo_r <= v4_r;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (en) begin
      f1_r    <= fld;
      ok2_r   <= f1_r.fmt_ok && mlook[4];
      y2_r    <= y_s2;
      base2_r <= base_s2;
      rest2_r <= rest_s2;
      ok3_r   <= ok2_r;
      y3_r    <= y2_r;
      base3_r <= base2_r;
      rest3_r <= rest2_r;
      prod3_r <= PROD_W'(PROD_W'(y2_r) * PROD_W'(RECIP));
      ok4_r   <= ok3_r;
      days4_r <= days_s4;
      rest4_r <= rest3_r;
      oko_r   <= ok4_r;
      secs_r  <= ok4_r ? secs_s5 : '0;
    end
  end

  assign res_valid = vo_r;
  assign res_ok    = oko_r;
  assign res_secs  = secs_r;

endmodule

### sv/http_date_parser.sv
// http date parser: one character accepted per cycle while the output is not stalled
// the result for a string passes the five pipeline registers after its last character is accepted
// throughput one character per cycle while not stalled, set by the single-pass parser state update
// a stalled result holds the five-stage seconds pipeline and input together
// synchronous active-low reset returns the parser to the weekday letters, pipeline empty
// depends on hdp_pkg, hdp_parser, hdp_epoch and http_date_parser_defines.svh
`include "http_date_parser_defines.svh"
module http_date_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // char_in
  input  logic        in_tlast,   // is_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // valid_res, epoch_seconds
);
  import hdp_pkg::*;

  logic             en, in_acc, fld_valid, res_ok;
  hdp_fields_t      fld;
  logic [SEC_W-1:0] res_secs;

  // whole path advances when the output register is free or drained
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;
  assign in_acc    = in_tvalid && en;

  hdp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_acc    (in_acc),
    .in_char   (in_tdata),
    .in_last   (in_tlast),
    .fld_valid (fld_valid),
    .fld       (fld)
  );

  hdp_epoch u_epoch (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .fld_valid (fld_valid),
    .fld       (fld),
    .res_valid (out_tvalid),
    .res_ok    (res_ok),
    .res_secs  (res_secs)
  );

  assign out_tdata = {res_secs, res_ok};

  `HDP_ASSERT(a_invalid_zero, clk, rst_n, out_tvalid && !out_tdata[0] |-> out_tdata[39:1] == '0)
  `HDP_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
  `HDP_ASSERT_RST(a_reset_empty, clk, !rst_n |=> !out_tvalid)

endmodule

### bench/http_date_parser_check.sv
// checker for the http date parser: watches both streams, predicts each date result
// depends on the port layout of http_date_parser only
`timescale 1ns / 100ps
module http_date_parser_check (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // char_in
  input  logic        in_tlast,   // is_last
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,  // valid_res, epoch_seconds
  output int          fail_count,
  output int          dates_pending
);

  localparam int MAX_DIGITS = 4;

  typedef enum logic [4:0] {
    P_WDAY, P_COMMA, P_SP1, P_SP1B, P_DAY, P_SP2, P_MON, P_MONEND, P_SP3, P_YEAR,
    P_SP4, P_HH2, P_C1, P_MM1, P_MM2, P_C2, P_SS1, P_SS2, P_SPZ, P_ZSTART,
    P_ZNAME, P_ZD1, P_ZD2, P_ZD3, P_ZD4, P_DONE
  } phase_t;

  string month_names = "janfebmaraprmayjunjulaugsepoctnovdec";
  string gmt_name = "gmt";

  phase_t       phase;
  logic [2:0]   dcnt;
  logic [13:0]  acc, day_v, year_v;
  logic [14:0]  mon_code;
  logic [6:0]   hour_v, min_v, sec_v, zhour_v;
  logic         zneg, zname_ok, broken;

  logic [39:0]  date_q[$];
  int           mismatches;

  assign fail_count = mismatches;
  assign dates_pending = date_q.size();

  task automatic clear_parse();
    phase = P_WDAY; dcnt = 0; acc = 0; day_v = 0; mon_code = 0; year_v = 0;
    hour_v = 0; min_v = 0; sec_v = 0; zneg = 0; zhour_v = 0; zname_ok = 1; broken = 0;
  endtask

  task automatic push_digit(input int d);
    if (dcnt >= MAX_DIGITS) begin
      broken = 1;
    end else begin
      acc = acc * 10 + d;
      dcnt++;
    end
  endtask

  task automatic zone_char(input logic [7:0] lc);
    if (dcnt >= 3 || lc != gmt_name[dcnt]) zname_ok = 0;
    if (dcnt < 7) dcnt++;
  endtask

  // one character through the pattern
  task automatic parse_char(input logic [7:0] c);
    logic       dig, letter, sp, ok;
    int         dv;
    logic [7:0] lc;
    phase_t     nxt;
    dig = c >= "0" && c <= "9";
    dv = dig ? c - "0" : 0;
    lc = c | 8'h20;
    letter = c < 128 && lc >= "a" && lc <= "z";
    sp = c == " ";
    nxt = phase;
    ok = 0;
    case (phase)
      P_WDAY: if (letter) begin
        ok = 1; dcnt++;
        if (dcnt >= 3) begin dcnt = 0; nxt = P_COMMA; end
      end
      P_COMMA: if (c == ",") begin ok = 1; nxt = P_SP1; end
      P_SP1: if (sp) begin ok = 1; nxt = P_SP1B; end
      P_SP1B: if (sp) ok = 1;
        else if (dig) begin ok = 1; acc = 0; dcnt = 0; push_digit(dv); nxt = P_DAY; end
      P_DAY: if (dig) begin ok = 1; push_digit(dv); end
        else if (sp) begin ok = 1; day_v = acc; nxt = P_SP2; end
      P_SP2: if (sp) ok = 1;
        else if (letter) begin ok = 1; mon_code = lc - "a"; dcnt = 1; nxt = P_MON; end
      P_MON: if (letter) begin
        ok = 1;
        mon_code = (mon_code << 5) | 15'(lc - "a");
        dcnt++;
        if (dcnt >= 3) begin dcnt = 0; nxt = P_MONEND; end
      end
      P_MONEND: if (sp) begin ok = 1; nxt = P_SP3; end
      P_SP3: if (sp) ok = 1;
        else if (dig) begin ok = 1; acc = 0; dcnt = 0; push_digit(dv); nxt = P_YEAR; end
      P_YEAR: if (dig) begin ok = 1; push_digit(dv); end
        else if (sp) begin ok = 1; year_v = acc; nxt = P_SP4; end
      P_SP4: if (sp) ok = 1;
        else if (dig) begin ok = 1; hour_v = dv; nxt = P_HH2; end
      P_HH2: if (dig) begin ok = 1; hour_v = hour_v * 10 + dv; nxt = P_C1; end
      P_C1: if (c == ":") begin ok = 1; nxt = P_MM1; end
      P_MM1: if (dig) begin ok = 1; min_v = dv; nxt = P_MM2; end
      P_MM2: if (dig) begin ok = 1; min_v = min_v * 10 + dv; nxt = P_C2; end
      P_C2: if (c == ":") begin ok = 1; nxt = P_SS1; end
      P_SS1: if (dig) begin ok = 1; sec_v = dv; nxt = P_SS2; end
      P_SS2: if (dig) begin ok = 1; sec_v = sec_v * 10 + dv; nxt = P_SPZ; end
      P_SPZ: if (sp) begin ok = 1; nxt = P_ZSTART; end
      P_ZSTART: if (sp) ok = 1;
        else if (letter) begin ok = 1; dcnt = 0; zone_char(lc); nxt = P_ZNAME; end
        else if (c == "+" || c == "-") begin ok = 1; zneg = c == "-"; nxt = P_ZD1; end
      P_ZNAME: if (letter) begin ok = 1; zone_char(lc); end
      P_ZD1: if (dig) begin ok = 1; zhour_v = dv; nxt = P_ZD2; end
      P_ZD2: if (dig) begin ok = 1; zhour_v = zhour_v * 10 + dv; nxt = P_ZD3; end
      P_ZD3: if (dig) begin ok = 1; acc = dv; nxt = P_ZD4; end
      P_ZD4: if (dig) begin ok = 1; acc = acc * 10 + dv; nxt = P_DONE; end
      default: ;
    endcase
    if (!ok) broken = 1;
    phase = nxt;
  endtask

  // days from 1970-01-01 to the first of month m (1..12), proleptic gregorian
  function automatic longint days_before(longint y, longint m);
    longint yy, era, yoe, mp, doe;
    yy = (m <= 2) ? y - 1 : y;
    era = (yy >= 0 ? yy : yy - 399) / 400;
    yoe = yy - era * 400;
    mp = (m + 9) % 12;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + (153 * mp + 2) / 5;
    return era * 146097 + doe - 719468;
  endfunction

  // verdict and seconds for the finished string, packed as on the bus
  function automatic logic [39:0] finish_date();
    logic       good;
    int         month;
    logic [14:0] code;
    longint     secs, tz;
    good = !broken && ((phase == P_ZNAME && zname_ok && dcnt == 3) || phase == P_DONE);
    month = -1;
    for (int i = 11; i >= 0; i--) begin
      code = {5'(month_names[3*i] - "a"), 5'(month_names[3*i+1] - "a"),
              5'(month_names[3*i+2] - "a")};
      if (code == mon_code) month = i;
    end
    if (month < 0) good = 0;
    if (!good) return 40'd0;
    tz = 0;
    if (phase == P_DONE) begin
      tz = longint'(zhour_v) * 3600 + longint'(acc) * 60;
      if (zneg) tz = -tz;
    end
    secs = (days_before(year_v, month + 1) + day_v - 1) * 86400 + longint'(hour_v) * 3600
           + longint'(min_v) * 60 + sec_v - tz;
    return {secs[38:0], 1'b1};
  endfunction

  initial clear_parse();

  always @(posedge clk) begin
    logic [39:0] want;
    if (rst_n) begin
      // predict on every accepted character
      if (in_tvalid && in_tready) begin
        if (!broken) parse_char(in_tdata);
        if (in_tlast) begin
          date_q.push_back(finish_date());
          clear_parse();
        end
      end
      // compare each delivered date with the oldest prediction
      if (out_tvalid && out_tready) begin
        if (date_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected date result %h", out_tdata);
        end else begin
          want = date_q.pop_front();
          if (want[0] !== out_tdata[0] || want[39:1] !== out_tdata[39:1]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("date mismatch: valid exp %0b got %0b, seconds exp %h got %h",
                       want[0], out_tdata[0], want[39:1], out_tdata[39:1]);
          end
        end
      end
    end
  end

endmodule

### bench/http_date_parser_test.sv
// top of the http date parser bench: clock, reset, character stimulus and verdict
// depends on http_date_parser and http_date_parser_check
`timescale 1ns / 100ps
module http_date_parser_test;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [7:0]  in_tdata = 0;   // char_in
  logic        in_tlast = 0;   // is_last
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [39:0] out_tdata;      // valid_res, epoch_seconds
  int          fail_count, dates_pending;

  int          chars_sent = 0;
  int          strings_sent = 0;
  bit          hold_request = 0;
  bit          quiet_gaps = 0;
  logic [7:0]  line[$];

  http_date_parser dut (.*);
  http_date_parser_check chk (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // run limit
  initial begin
    repeat (600000) @(posedge clk);
    $display("http_date_parser test failed");
    $finish;
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(15, 60);
    return $urandom_range(1, 3);
  endfunction

  // receiver: random stalls plus one long hold-off on request
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_tready <= 0;
        hold_request = 0;
        repeat (400) @(negedge clk);
      end else if (!quiet_gaps && $urandom_range(0, 3) == 0) begin
        out_tready <= 0;
        repeat (pick_gap() - 1) @(negedge clk);
      end else begin
        out_tready <= 1;
      end
    end
  end

  // sends the whole line, last character marked
  task automatic send_line();
    for (int i = 0; i < line.size(); i++) begin
      @(negedge clk);
      in_tvalid <= 1;
      in_tdata <= line[i];
      in_tlast <= i == line.size() - 1;
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      chars_sent++;
      if (!quiet_gaps && $urandom_range(0, 4) == 0) begin
        @(negedge clk);
        in_tvalid <= 0;
        repeat (pick_gap() - 1) @(negedge clk);
      end
    end
    strings_sent++;
  endtask

  task automatic load_text(input string s);
    line.delete();
    for (int i = 0; i < s.len(); i++) line.push_back(s[i]);
  endtask

  function automatic logic [7:0] mix_case(input logic [7:0] ch);
    return $urandom_range(0, 1) ? (ch ^ 8'h20) : ch;
  endfunction

  task automatic add_spaces();
    repeat ($urandom_range(0, 9) == 0 ? $urandom_range(2, 4) : 1) line.push_back(" ");
  endtask

  task automatic add_digits(input int n);
    repeat (n) line.push_back(8'("0" + $urandom_range(0, 9)));
  endtask

  // well-formed shape with random content, then maybe damaged
  task automatic build_random_date();
    string months = "janfebmaraprmayjunjulaugsepoctnovdec";
    int    m;
    line.delete();
    repeat (3) line.push_back(mix_case(8'($urandom_range("a", "z"))));
    line.push_back(",");
    add_spaces();
    add_digits($urandom_range(0, 15) == 0 ? 5 : $urandom_range(1, 4));
    add_spaces();
    m = $urandom_range(0, 11);
    for (int k = 0; k < 3; k++) begin
      if ($urandom_range(0, 29) == 0) line.push_back(mix_case(8'($urandom_range("a", "z"))));
      else line.push_back(mix_case(months[3*m+k]));
    end
    add_spaces();
    add_digits($urandom_range(0, 15) == 0 ? 5 : $urandom_range(1, 4));
    add_spaces();
    add_digits(2); line.push_back(":"); add_digits(2); line.push_back(":"); add_digits(2);
    add_spaces();
    case ($urandom_range(0, 5))
      0, 1: begin
        line.push_back(mix_case("g")); line.push_back(mix_case("m")); line.push_back(mix_case("t"));
      end
      2: repeat ($urandom_range(1, 8)) line.push_back(mix_case(8'($urandom_range("a", "z"))));
      default: begin
        line.push_back($urandom_range(0, 1) ? "-" : "+");
        add_digits(4);
      end
    endcase
    case ($urandom_range(0, 9))
      0, 1: line[$urandom_range(0, line.size() - 1)] = 8'($urandom_range(0, 255));
      2: repeat ($urandom_range(1, line.size() - 1)) void'(line.pop_back());
      default: ;
    endcase
  endtask

  task automatic build_noise();
    line.delete();
    repeat ($urandom_range(1, 12)) line.push_back(8'($urandom_range(0, 255)));
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // directed strings: reference date, extremes, each failure kind
    quiet_gaps = 1;
    load_text("Sun, 06 Nov 1994 08:49:37 GMT"); send_line();
    quiet_gaps = 0;
    load_text("mOn,   0 jAn 0  00:00:00   +0000"); send_line();
    load_text("Xyz, 9999 DEC 9999 99:99:99 -9999"); send_line();
    load_text("Tue, 29 Feb 2000 23:59:59 +9999"); send_line();
    load_text("Wed, 12345 Mar 2001 10:00:00 GMT"); send_line();
    load_text("Thu, 1 Foo 2001 10:00:00 GMT"); send_line();
    load_text("Fri, 1 Apr 2001 10:00:00 GMTX"); send_line();
    load_text("Sat, 1 May 2001 10:0"); send_line();
    line.delete(); line.push_back(8'hC1); send_line();
    load_text("Z"); send_line();

    // random strings, with one long receiver hold-off early on
    while (chars_sent < 1100) begin
      if (strings_sent == 20) hold_request = 1;
      if (strings_sent % 15 == 0) quiet_gaps = $urandom_range(0, 2) == 0;
      if ($urandom_range(0, 5) == 0) build_noise();
      else build_random_date();
      send_line();
    end
    @(negedge clk);
    in_tvalid <= 0;

    while (dates_pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("http_date_parser test passed");
    end else begin
      $display("http_date_parser test failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/hdp_pkg.sv
sv/hdp_parser.sv
sv/hdp_epoch.sv
sv/http_date_parser.sv
bench/http_date_parser_check.sv
bench/http_date_parser_test.sv
